// ===== src/abtt_pkg.sv =====
// Shared widths, codes and defaults for the array binary tree traversal block.
package abtt_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int VALUE_BITS_DEF = 32;

   localparam int KIND_W      = 2;
   localparam int IDX_W       = 6;
   localparam int OUT_W       = 32;
   localparam int ORDER_W     = 2;
   localparam int STATUS_W    = 2;
   localparam int STACK_DEPTH = 6;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [ORDER_W-1:0]  order_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_WRITE  = 2'd0;
   localparam kind_type KIND_DELETE = 2'd1;
   localparam kind_type KIND_WALK   = 2'd2;
   localparam kind_type KIND_NOP    = 2'd3;

   // visit phases use the same codes as the walk orders
   localparam order_type ORDER_PRE      = 2'd0;
   localparam order_type ORDER_IN       = 2'd1;
   localparam order_type ORDER_POST     = 2'd2;
   localparam order_type ORDER_POST_ALT = 2'd3;

   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_ABSENT = 2'd1;
   localparam status_type STATUS_RANGE  = 2'd2;

endpackage

// ===== src/abtt_node_mem.sv =====
// Node value store: single write port, single read port with registered read data.
module abtt_node_mem #(
   parameter int DEPTH = abtt_pkg::CAPACITY_DEF,
   parameter int WIDTH = abtt_pkg::VALUE_BITS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic signed [WIDTH-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output logic signed [WIDTH-1:0] rd_data
);

   logic signed [WIDTH-1:0] mem [DEPTH];
   logic signed [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/array_binary_tree_traversal_core.sv =====
// Top level: heap-indexed binary tree store with preorder/inorder/postorder walks.
// Write, delete, out-of-range and empty-walk items: result registered in the cycle after the request is taken.
// Walk: one stack step per cycle while the result path does not stall, three steps
// per visited node; each step updates or pops the top stack entry and may push a child.
// Each visited value is one node store read, held until the next read or the walk's end.
// Reset clears valid bits, stack pointer and handshake state, but not the node store.
module array_binary_tree_traversal_core #(
   parameter int CAPACITY   = abtt_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = abtt_pkg::VALUE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [abtt_pkg::KIND_W-1:0]       req_kind,
   input  logic [abtt_pkg::IDX_W-1:0]        req_node_index,
   input  logic signed [abtt_pkg::OUT_W-1:0] req_node_value,
   input  logic [abtt_pkg::ORDER_W-1:0]      req_walk_order,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [abtt_pkg::OUT_W-1:0] rsp_out_value,
   output logic [abtt_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_last
);

   localparam int AW     = $clog2(CAPACITY);
   localparam int DEPTH  = abtt_pkg::STACK_DEPTH;
   localparam int STK_AW = $clog2(DEPTH);
   localparam int SP_W   = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic                         state_ff, state_in;
   logic [SP_W-1:0]              sp_ff, sp_in;
   logic                         held_ff, held_in;
   abtt_pkg::order_type          order_ff, order_in;
   logic [CAPACITY-1:0]          valid_ff;

   abtt_pkg::idx_type            stk_node_ff  [DEPTH];
   abtt_pkg::order_type          stk_phase_ff [DEPTH];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [abtt_pkg::OUT_W-1:0] rsp_value_ff;
   abtt_pkg::status_type         rsp_status_ff;
   logic                         rsp_last_ff;

   logic                         rsp_load;
   logic signed [abtt_pkg::OUT_W-1:0] load_value;
   abtt_pkg::status_type         load_status;
   logic                         load_last;

   logic                         slot_free, req_fire, in_range, node_valid;
   logic [AW-1:0]                req_addr;
   logic [STK_AW-1:0]            top_idx;
   abtt_pkg::idx_type            top_node;
   abtt_pkg::order_type          top_phase;
   logic [abtt_pkg::IDX_W:0]     child_l, child_r;
   logic                         present_l, present_r;
   logic                         emit, stall, has_room;

   logic                         mem_we, mem_re;
   logic signed [VALUE_BITS-1:0] mem_wdata, mem_rdata;

   logic                         valid_set, valid_clr, walk_start;
   logic                         top_set, push;
   abtt_pkg::order_type          top_phase_new;
   logic [abtt_pkg::IDX_W:0]     push_node;

   assign req_addr   = req_node_index[AW-1:0];
   assign in_range   = (req_node_index != '0) && (32'(req_node_index) < CAPACITY);
   assign node_valid = valid_ff[req_addr];
   assign mem_wdata  = VALUE_BITS'(req_node_value);

   assign top_idx   = STK_AW'(sp_ff - 1'b1);
   assign top_node  = stk_node_ff[top_idx];
   assign top_phase = stk_phase_ff[top_idx];
   assign child_l   = {top_node, 1'b0};
   assign child_r   = {top_node, 1'b1};
   // children at or beyond capacity count as absent
   assign present_l = (32'(child_l) < CAPACITY) && valid_ff[child_l[AW-1:0]];
   assign present_r = (32'(child_r) < CAPACITY) && valid_ff[child_r[AW-1:0]];
   assign has_room  = (32'(sp_ff) < DEPTH);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign emit      = (top_phase == order_ff);
   // a held value can only move out when the output slot frees up
   assign stall     = emit && held_ff && !slot_free;

   abtt_node_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_BITS),
      .AW    (AW)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (req_addr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (top_node[AW-1:0]),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      held_in       = held_ff;
      order_in      = order_ff;
      rsp_load      = 1'b0;
      load_value    = '0;
      load_status   = abtt_pkg::STATUS_OK;
      load_last     = 1'b1;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      valid_set     = 1'b0;
      valid_clr     = 1'b0;
      walk_start    = 1'b0;
      top_set       = 1'b0;
      top_phase_new = abtt_pkg::ORDER_PRE;
      push          = 1'b0;
      push_node     = child_l;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind != abtt_pkg::KIND_NOP)) begin
               if (!in_range) begin
                  rsp_load    = 1'b1;
                  load_status = abtt_pkg::STATUS_RANGE;
               end else begin
                  case (req_kind)
                     abtt_pkg::KIND_WRITE: begin
                        mem_we    = 1'b1;
                        valid_set = 1'b1;
                        rsp_load  = 1'b1;
                     end
                     abtt_pkg::KIND_DELETE: begin
                        rsp_load    = 1'b1;
                        valid_clr   = node_valid;
                        load_status = node_valid ? abtt_pkg::STATUS_OK
                                                 : abtt_pkg::STATUS_ABSENT;
                     end
                     abtt_pkg::KIND_WALK: begin
                        if (!node_valid) begin
                           rsp_load    = 1'b1;
                           load_status = abtt_pkg::STATUS_ABSENT;
                        end else begin
                           walk_start = 1'b1;
                           sp_in      = SP_W'(1);
                           held_in    = 1'b0;
                           state_in   = ST_WALK;
                           order_in   = (req_walk_order == abtt_pkg::ORDER_POST_ALT) ?
                                        abtt_pkg::ORDER_POST : req_walk_order;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_WALK: begin
            if (sp_ff == '0) begin
               // stack drained: the held value is the final result
               if (slot_free) begin
                  rsp_load   = 1'b1;
                  load_value = 32'(mem_rdata);
                  held_in    = 1'b0;
                  state_in   = ST_IDLE;
               end
            end else if (!stall) begin
               if (emit) begin
                  mem_re  = 1'b1;
                  held_in = 1'b1;
                  if (held_ff) begin
                     rsp_load   = 1'b1;
                     load_value = 32'(mem_rdata);
                     load_last  = 1'b0;
                  end
               end
               case (top_phase)
                  abtt_pkg::ORDER_PRE: begin
                     top_set       = 1'b1;
                     top_phase_new = abtt_pkg::ORDER_IN;
                     push          = present_l && has_room;
                     push_node     = child_l;
                  end
                  abtt_pkg::ORDER_IN: begin
                     top_set       = 1'b1;
                     top_phase_new = abtt_pkg::ORDER_POST;
                     push          = present_r && has_room;
                     push_node     = child_r;
                  end
                  default: begin
                     sp_in = sp_ff - 1'b1;
                  end
               endcase
               if (push) begin
                  sp_in = sp_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         held_ff      <= 1'b0;
         order_ff     <= abtt_pkg::ORDER_PRE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         held_ff      <= held_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
         if (valid_set) begin
            valid_ff[req_addr] <= 1'b1;
         end else if (valid_clr) begin
            valid_ff[req_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff  <= load_value;
         rsp_status_ff <= load_status;
         rsp_last_ff   <= load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (walk_start) begin
         stk_node_ff[0]  <= req_node_index;
         stk_phase_ff[0] <= abtt_pkg::ORDER_PRE;
      end else begin
         if (top_set) begin
            stk_phase_ff[top_idx] <= top_phase_new;
         end
         if (push) begin
            stk_node_ff[sp_ff[STK_AW-1:0]]  <= push_node[abtt_pkg::IDX_W-1:0];
            stk_phase_ff[sp_ff[STK_AW-1:0]] <= abtt_pkg::ORDER_PRE;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) <= DEPTH)
      else $error("walk stack pointer beyond depth");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (sp_ff == '0) && !held_ff)
      else $error("walk state left behind in idle");

   a_end_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && (sp_ff == '0) |-> held_ff)
      else $error("walk finished with no value to emit");

   a_walk_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !req_ready)
      else $error("request taken during walk");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && (sp_ff != '0) && stall |=> $stable(sp_ff))
      else $error("stack moved while result path stalled");

endmodule

// ===== tb/sv/tree_result_checker.sv =====
// Transfer monitor, tree predictor and result comparator for the traversal core.
`timescale 1ns / 100ps
module tree_result_checker #(
   parameter int CAPACITY = abtt_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [abtt_pkg::KIND_W-1:0]       req_kind,
   input  logic [abtt_pkg::IDX_W-1:0]        req_node_index,
   input  logic signed [abtt_pkg::OUT_W-1:0] req_node_value,
   input  logic [abtt_pkg::ORDER_W-1:0]      req_walk_order,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [abtt_pkg::OUT_W-1:0] rsp_out_value,
   input  logic [abtt_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                              rsp_last,
   output int                                mismatch_total,
   output int                                results_pending
);

   typedef struct packed {
      logic signed [abtt_pkg::OUT_W-1:0] value;
      abtt_pkg::status_type              status;
      logic                              last;
   } tree_result_type;

   logic signed [abtt_pkg::OUT_W-1:0] node_store [CAPACITY];
   logic                              node_valid [CAPACITY];
   logic [7:0]                        walk_frames [abtt_pkg::STACK_DEPTH];
   int unsigned                       walk_depth;
   tree_result_type                   expected_results [$];
   int                                mismatches = 0;

   assign mismatch_total = mismatches;

   function automatic bit node_present(int idx);
      return idx < CAPACITY && node_valid[idx];
   endfunction

   // frames hold the node index low and its visit phase in the top two bits
   function automatic void push_frame(int idx);
      if (walk_depth < abtt_pkg::STACK_DEPTH) begin
         walk_frames[walk_depth] = {abtt_pkg::ORDER_PRE, abtt_pkg::idx_type'(idx)};
         walk_depth++;
      end
   endfunction

   function automatic void expect_result(logic signed [abtt_pkg::OUT_W-1:0] value,
                                         abtt_pkg::status_type status, logic last);
      tree_result_type r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      expected_results.push_back(r);
   endfunction

   function automatic void predict_walk(abtt_pkg::idx_type root,
                                        abtt_pkg::order_type requested);
      abtt_pkg::order_type               visit_phase;
      abtt_pkg::order_type               phase;
      abtt_pkg::idx_type                 node;
      int                                child;
      logic signed [abtt_pkg::OUT_W-1:0] visited [$];
      if (!node_valid[root]) begin
         expect_result('0, abtt_pkg::STATUS_ABSENT, 1'b1);
         return;
      end
      visit_phase = (requested == abtt_pkg::ORDER_POST_ALT) ? abtt_pkg::ORDER_POST
                                                            : requested;
      walk_depth = 0;
      push_frame(root);
      while (walk_depth > 0) begin
         node  = walk_frames[walk_depth-1][abtt_pkg::IDX_W-1:0];
         phase = walk_frames[walk_depth-1][7:6];
         child = 2 * int'(node);
         if (phase == visit_phase && visited.size() < 64)
            visited.push_back(node_store[node]);
         if (phase == abtt_pkg::ORDER_PRE) begin
            walk_frames[walk_depth-1] = {abtt_pkg::ORDER_IN, node};
            if (node_present(child))
               push_frame(child);
         end else if (phase == abtt_pkg::ORDER_IN) begin
            walk_frames[walk_depth-1] = {abtt_pkg::ORDER_POST, node};
            if (node_present(child + 1))
               push_frame(child + 1);
         end else begin
            walk_depth--;
         end
      end
      walk_depth = 0;
      foreach (visited[k])
         expect_result(visited[k], abtt_pkg::STATUS_OK, k == visited.size() - 1);
   endfunction

   function automatic void predict_tree_op(abtt_pkg::kind_type kind, abtt_pkg::idx_type idx,
                                           logic signed [abtt_pkg::OUT_W-1:0] value,
                                           abtt_pkg::order_type order);
      if (kind == abtt_pkg::KIND_NOP)
         return;
      if (idx == 0 || idx >= CAPACITY) begin
         expect_result('0, abtt_pkg::STATUS_RANGE, 1'b1);
         return;
      end
      case (kind)
         abtt_pkg::KIND_WRITE: begin
            node_store[idx] = value;
            node_valid[idx] = 1'b1;
            expect_result('0, abtt_pkg::STATUS_OK, 1'b1);
         end
         abtt_pkg::KIND_DELETE: begin
            if (node_valid[idx]) begin
               node_valid[idx] = 1'b0;
               expect_result('0, abtt_pkg::STATUS_OK, 1'b1);
            end else begin
               expect_result('0, abtt_pkg::STATUS_ABSENT, 1'b1);
            end
         end
         default: predict_walk(idx, order);
      endcase
   endfunction

   always @(posedge clock) begin
      tree_result_type want;
      if (reset) begin
         foreach (node_valid[i])
            node_valid[i] = 1'b0;
         walk_depth = 0;
         expected_results.delete();
      end else begin
         // a result never comes from the request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, got value %0d status %0d %s %0d",
                        $time, rsp_out_value, rsp_status, "last", rsp_last);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_value !== want.value) begin
                  $display("%0t: out_value expected %0d, got %0d",
                           $time, want.value, rsp_out_value);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0d, got %0d", $time, want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_tree_op(req_kind, req_node_index, req_node_value, req_walk_order);
      end
      results_pending = expected_results.size();
   end

endmodule

// ===== tb/sv/array_binary_tree_traversal_core_tb.sv =====
// Testbench top for the traversal core: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module array_binary_tree_traversal_core_tb;

   localparam int RANDOM_ITEMS = 480;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 250;

   logic                              clock          = 1'b0;
   logic                              reset          = 1'b1;
   logic                              req_valid      = 1'b0;
   logic                              req_ready;
   abtt_pkg::kind_type                req_kind       = abtt_pkg::KIND_WRITE;
   abtt_pkg::idx_type                 req_node_index = '0;
   logic signed [abtt_pkg::OUT_W-1:0] req_node_value = '0;
   abtt_pkg::order_type               req_walk_order = abtt_pkg::ORDER_PRE;
   logic                              rsp_valid;
   logic                              rsp_ready      = 1'b0;
   logic signed [abtt_pkg::OUT_W-1:0] rsp_out_value;
   abtt_pkg::status_type              rsp_status;
   logic                              rsp_last;

   int fail_count;
   int outstanding;
   int items_sent       = 0;
   int no_idle_left     = 0;
   bit rsp_hold_request = 1'b0;

   always #5 clock = ~clock;

   array_binary_tree_traversal_core DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_kind, .req_node_index, .req_node_value, .req_walk_order,
      .rsp_valid, .rsp_ready, .rsp_out_value, .rsp_status, .rsp_last
   );

   tree_result_checker u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_kind, .req_node_index, .req_node_value, .req_walk_order,
      .rsp_valid, .rsp_ready, .rsp_out_value, .rsp_status, .rsp_last,
      .mismatch_total  (fail_count),
      .results_pending (outstanding)
   );

   function automatic int idle_cycles();
      int r;
      if (no_idle_left > 0) begin
         no_idle_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         no_idle_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   function automatic logic signed [abtt_pkg::OUT_W-1:0] random_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return -32'sd1;
         3:       return '0;
         default: return $urandom();
      endcase
   endfunction

   function automatic abtt_pkg::order_type random_order();
      return abtt_pkg::order_type'($urandom_range(0, 3));
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(abtt_pkg::kind_type kind, abtt_pkg::idx_type node_idx,
                            logic signed [abtt_pkg::OUT_W-1:0] value,
                            abtt_pkg::order_type walk_ord);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_node_index <= node_idx;
      req_node_value <= value;
      req_walk_order <= walk_ord;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (kind != abtt_pkg::KIND_NOP)
         items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // well-formed sequence: a connected subtree under a shallow root, sometimes a delete, then a walk
   task automatic grow_subtree();
      abtt_pkg::idx_type members [$];
      abtt_pkg::idx_type parent;
      int                child;
      int                count;
      members.push_back(abtt_pkg::idx_type'($urandom_range(1, 7)));
      send_item(abtt_pkg::KIND_WRITE, members[0], random_value(), random_order());
      count = $urandom_range(1, 12);
      repeat (count) begin
         parent = members[$urandom_range(0, members.size() - 1)];
         child  = 2 * int'(parent) + $urandom_range(0, 1);
         if (child < abtt_pkg::CAPACITY_DEF) begin
            members.push_back(abtt_pkg::idx_type'(child));
            send_item(abtt_pkg::KIND_WRITE, abtt_pkg::idx_type'(child), random_value(),
                      random_order());
         end
      end
      if ($urandom_range(0, 3) == 0)
         send_item(abtt_pkg::KIND_DELETE, members[$urandom_range(0, members.size() - 1)],
                   random_value(), random_order());
      if ($urandom_range(0, 1) == 0)
         send_item(abtt_pkg::KIND_WALK, members[0], random_value(), random_order());
      else
         send_item(abtt_pkg::KIND_WALK, members[$urandom_range(0, members.size() - 1)],
                   random_value(), random_order());
   endtask

   task automatic random_item();
      abtt_pkg::kind_type kind;
      abtt_pkg::idx_type  node_idx;
      int                 r;
      r = $urandom_range(0, 99);
      node_idx = abtt_pkg::idx_type'($urandom_range(1, abtt_pkg::CAPACITY_DEF - 1));
      if (r < 4) begin
         kind     = abtt_pkg::KIND_NOP;
         node_idx = abtt_pkg::idx_type'($urandom_range(0, abtt_pkg::CAPACITY_DEF - 1));
      end else if (r < 8) begin
         kind     = abtt_pkg::kind_type'($urandom_range(0, 2));
         node_idx = '0;
      end else if (r < 50) begin
         kind = abtt_pkg::KIND_WRITE;
      end else if (r < 68) begin
         kind = abtt_pkg::KIND_DELETE;
      end else begin
         kind = abtt_pkg::KIND_WALK;
         if ($urandom_range(0, 1) == 0)
            node_idx = abtt_pkg::idx_type'($urandom_range(1, 7));
      end
      send_item(kind, node_idx, random_value(), random_order());
   endtask

   initial begin
      int target;
      bit hold_done;
      bit pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // index zero, ignored kind, empty tree
      send_item(abtt_pkg::KIND_WRITE, '0, 32'sd77, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_DELETE, '0, '0, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WALK, '0, '0, abtt_pkg::ORDER_IN);
      send_item(abtt_pkg::KIND_NOP, 6'd5, 32'sd9, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_NOP, '0, '0, abtt_pkg::ORDER_POST_ALT);
      send_item(abtt_pkg::KIND_WALK, 6'd1, '0, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_DELETE, 6'd1, '0, abtt_pkg::ORDER_PRE);
      // small tree with extreme values, and a lone deepest node
      send_item(abtt_pkg::KIND_WRITE, 6'd1, 32'sh7FFF_FFFF, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WRITE, 6'd2, 32'sh8000_0000, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WRITE, 6'd3, -32'sd1, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WRITE, 6'd4, '0, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WRITE, 6'd5, 32'sh5A5A_A5A5, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WRITE, 6'd7, 32'shA5A5_5A5A, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WRITE, 6'd63, 32'sd12345, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WALK, 6'd1, '0, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WALK, 6'd1, '0, abtt_pkg::ORDER_IN);
      send_item(abtt_pkg::KIND_WALK, 6'd1, '0, abtt_pkg::ORDER_POST);
      send_item(abtt_pkg::KIND_WALK, 6'd1, '0, abtt_pkg::ORDER_POST_ALT);
      send_item(abtt_pkg::KIND_WALK, 6'd63, '0, abtt_pkg::ORDER_IN);
      send_item(abtt_pkg::KIND_WALK, 6'd31, '0, abtt_pkg::ORDER_PRE);
      // deleting an inner node cuts its subtree off from the root only
      send_item(abtt_pkg::KIND_DELETE, 6'd2, '0, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WALK, 6'd1, '0, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WALK, 6'd4, '0, abtt_pkg::ORDER_POST);
      send_item(abtt_pkg::KIND_WRITE, 6'd2, 32'sd1, abtt_pkg::ORDER_PRE);
      send_item(abtt_pkg::KIND_WALK, 6'd2, '0, abtt_pkg::ORDER_IN);
      drain_results();

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (!hold_done && items_sent >= target - 330) begin
            rsp_hold_request = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && items_sent >= target - 160) begin
            drain_results();
            pause_done = 1'b1;
         end
         if ($urandom_range(0, 9) < 6)
            grow_subtree();
         else
            random_item();
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // result side: random stalls, steady stretches, and one long hold on request
   initial begin
      int r;
      int gap;
      int steady;
      bit hold_taken;
      steady     = 0;
      hold_taken = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_request && !hold_taken) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_taken = 1'b1;
         end else if (steady > 0) begin
            rsp_ready <= 1'b1;
            steady--;
            @(negedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               steady = $urandom_range(20, 80);
               rsp_ready <= 1'b1;
               @(negedge clock);
            end else if (r < 60) begin
               rsp_ready <= 1'b1;
               @(negedge clock);
            end else begin
               rsp_ready <= 1'b0;
               gap = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 25);
               repeat (gap) @(negedge clock);
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
